### rtl/sfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types, codes and the CRC16-CCITT byte update for the sync frame
// parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

    typedef logic [2:0] t_event;
    typedef logic [1:0] t_cfg_index;

    // event codes on the result channel
    localparam t_event EV_NONE     = 3'd0;
    localparam t_event EV_PAYLOAD  = 3'd1;
    localparam t_event EV_GOOD     = 3'd2;
    localparam t_event EV_BAD_CRC  = 3'd3;
    localparam t_event EV_OVERSIZE = 3'd4;

    // configuration register indexes
    localparam t_cfg_index CFG_SYNC_FIRST  = 2'd0;
    localparam t_cfg_index CFG_SYNC_SECOND = 2'd1;
    localparam t_cfg_index CFG_CAPACITY    = 2'd2;

    localparam logic [7:0]  SYNC_RST     = 8'h00;
    localparam logic [15:0] CAPACITY_RST = 16'd256;

    // header layout: version, type, node id, length low, length high
    localparam int          HDR_BYTES  = 5;
    localparam logic [2:0]  HDR_COUNT  = 3'(HDR_BYTES);
    localparam logic [2:0]  HDR_LAST   = 3'(HDR_BYTES - 1);
    localparam int          HDR_VER    = 0;
    localparam int          HDR_TYPE   = 1;
    localparam int          HDR_NODE   = 2;
    localparam int          HDR_LEN_LO = 3;
    localparam int          HDR_LEN_HI = 4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // CRC16-CCITT, MSB first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### rtl/sync_frame_parser_crc16.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_frame_parser_crc16
// Streaming parser for sync-framed packets checked by CRC16-CCITT.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one received byte per
//   word. Output channel (o_out_valid / i_out_ready) carries exactly one
//   result word per input word: none, payload byte with its index, frame
//   good, CRC mismatch, or oversize dropped, with the header and CRC fields.
//   Config channel (i_cfg_valid / o_cfg_ready) writes sync_first (0),
//   sync_second (1) and payload_capacity (2); other indexes are ignored.
//   The config channel is always ready; write it only while the parser idles.
//   A word accepted into the input register is parsed combinationally and
//   loads the result register, which drives o_out_valid.
//   Throughput: one byte per cycle while the receiver takes results; the
//   CRC byte update is a fixed XOR network between the input register and
//   the result register.
//   Reset: parser returns to hunting the first sync byte, CRC to 0xFFFF,
//   registers to sync bytes 0 and capacity 256; both channels empty.
//   Receiver stall: the result register holds, the input register takes
//   one more word, then o_in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module sync_frame_parser_crc16 (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // byte input
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [7:0]              i_rx_byte,
    // result output
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [2:0]              o_event_res,
    output logic [7:0]              o_payload_byte,
    output logic [15:0]             o_payload_index,
    output logic [7:0]              o_hdr_version,
    output logic [7:0]              o_hdr_msg_type,
    output logic [7:0]              o_hdr_node_id,
    output logic [15:0]             o_hdr_length,
    output logic [15:0]             o_crc_received,
    output logic [15:0]             o_crc_computed,
    // configuration writes
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [15:0]             i_cfg_data
);

    localparam logic [2:0] PH_HUNT0   = 3'd0;
    localparam logic [2:0] PH_HUNT1   = 3'd1;
    localparam logic [2:0] PH_HEADER  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CRC0    = 3'd4;
    localparam logic [2:0] PH_CRC1    = 3'd5;

    localparam int HDR_BYTES_L = sfp_pkg::HDR_BYTES;

    // configuration
    logic [7:0]  r_sync_first;
    logic [7:0]  r_sync_second;
    logic [15:0] r_capacity;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // parser state
    logic [2:0]  r_phase,   n_phase;
    logic [2:0]  r_hdr_cnt, n_hdr_cnt;
    logic [15:0] r_len,     n_len;
    logic [15:0] r_pay_cnt, n_pay_cnt;
    logic [15:0] r_crc,     n_crc;
    logic [7:0]  r_crc_lo,  n_crc_lo;
    logic [7:0]  r_hdr [HDR_BYTES_L];

    // result register
    logic                 r_out_valid;
    sfp_pkg::t_event      r_event,     n_event;
    logic [7:0]           r_pay_byte,  n_pay_byte;
    logic [15:0]          r_pay_index, n_pay_index;
    logic [7:0]           r_hdr_ver,   n_hdr_ver;
    logic [7:0]           r_hdr_type,  n_hdr_type;
    logic [7:0]           r_hdr_node,  n_hdr_node;
    logic [15:0]          r_hdr_len,   n_hdr_len;
    logic [15:0]          r_crc_rx,    n_crc_rx;
    logic [15:0]          r_crc_gen,   n_crc_gen;

    logic        w_adv;
    logic        w_fire;
    logic        w_hdr_wr;
    logic [15:0] w_crc_upd;
    logic [15:0] w_hdr_length;
    logic [15:0] w_pay_next;
    logic [15:0] w_rx_crc;

    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_fire     = r_in_valid && w_adv;
    assign o_in_ready = !r_in_valid || w_adv;
    assign o_cfg_ready = 1'b1;

    assign w_crc_upd    = sfp_pkg::crc16_byte(r_crc, r_in_byte);
    assign w_hdr_wr     = (r_phase == PH_HEADER) && (r_hdr_cnt < sfp_pkg::HDR_COUNT);
    // the last header byte arrives this cycle, so take it straight from input
    assign w_hdr_length = (r_hdr_cnt == sfp_pkg::HDR_LAST)
                        ? {r_in_byte, r_hdr[sfp_pkg::HDR_LEN_LO]}
                        : {r_hdr[sfp_pkg::HDR_LEN_HI], r_hdr[sfp_pkg::HDR_LEN_LO]};
    assign w_pay_next   = r_pay_cnt + 16'd1;
    assign w_rx_crc     = {r_in_byte, r_crc_lo};

    always_comb begin
        n_phase     = r_phase;
        n_hdr_cnt   = r_hdr_cnt;
        n_len       = r_len;
        n_pay_cnt   = r_pay_cnt;
        n_crc       = r_crc;
        n_crc_lo    = r_crc_lo;
        n_event     = sfp_pkg::EV_NONE;
        n_pay_byte  = 8'h00;
        n_pay_index = 16'h0000;
        n_hdr_ver   = 8'h00;
        n_hdr_type  = 8'h00;
        n_hdr_node  = 8'h00;
        n_hdr_len   = 16'h0000;
        n_crc_rx    = 16'h0000;
        n_crc_gen   = 16'h0000;

        case (r_phase)
            PH_HUNT1: begin
                if (r_in_byte == r_sync_second) begin
                    n_phase   = PH_HEADER;
                    n_hdr_cnt = 3'd0;
                    n_crc     = sfp_pkg::CRC_INIT;
                end else if (r_in_byte != r_sync_first) begin
                    n_phase = PH_HUNT0;
                end
            end
            PH_HEADER: begin
                if (w_hdr_wr) begin
                    n_hdr_cnt = r_hdr_cnt + 3'd1;
                    n_crc     = w_crc_upd;
                end
                if (r_hdr_cnt >= sfp_pkg::HDR_LAST) begin
                    n_len = w_hdr_length;
                    if (w_hdr_length > r_capacity) begin
                        // drop the frame and go back to hunting
                        n_event   = sfp_pkg::EV_OVERSIZE;
                        n_hdr_len = w_hdr_length;
                        n_phase   = PH_HUNT0;
                        n_hdr_cnt = 3'd0;
                        n_len     = 16'h0000;
                        n_pay_cnt = 16'h0000;
                        n_crc     = sfp_pkg::CRC_INIT;
                        n_crc_lo  = 8'h00;
                    end else begin
                        n_pay_cnt = 16'h0000;
                        n_phase   = (w_hdr_length != 16'h0000) ? PH_PAYLOAD : PH_CRC0;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_event     = sfp_pkg::EV_PAYLOAD;
                n_pay_byte  = r_in_byte;
                n_pay_index = r_pay_cnt;
                n_crc       = w_crc_upd;
                n_pay_cnt   = w_pay_next;
                if (w_pay_next >= r_len) begin
                    n_phase = PH_CRC0;
                end
            end
            PH_CRC0: begin
                n_crc_lo = r_in_byte;
                n_phase  = PH_CRC1;
            end
            PH_CRC1: begin
                n_event    = (w_rx_crc == r_crc) ? sfp_pkg::EV_GOOD : sfp_pkg::EV_BAD_CRC;
                n_hdr_ver  = r_hdr[sfp_pkg::HDR_VER];
                n_hdr_type = r_hdr[sfp_pkg::HDR_TYPE];
                n_hdr_node = r_hdr[sfp_pkg::HDR_NODE];
                n_hdr_len  = r_len;
                n_crc_rx   = w_rx_crc;
                n_crc_gen  = r_crc;
                n_phase    = PH_HUNT0;
                n_hdr_cnt  = 3'd0;
                n_len      = 16'h0000;
                n_pay_cnt  = 16'h0000;
                n_crc      = sfp_pkg::CRC_INIT;
                n_crc_lo   = 8'h00;
            end
            default: begin
                // hunting first sync byte; unused codes land here too
                n_phase = (r_in_byte == r_sync_first) ? PH_HUNT1 : PH_HUNT0;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= sfp_pkg::SYNC_RST;
            r_sync_second <= sfp_pkg::SYNC_RST;
            r_capacity    <= sfp_pkg::CAPACITY_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                sfp_pkg::CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data[7:0];
                sfp_pkg::CFG_SYNC_SECOND: r_sync_second <= i_cfg_data[7:0];
                sfp_pkg::CFG_CAPACITY:    r_capacity    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register and handshake state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT0;
            r_hdr_cnt <= 3'd0;
            r_len     <= 16'h0000;
            r_pay_cnt <= 16'h0000;
            r_crc     <= sfp_pkg::CRC_INIT;
            r_crc_lo  <= 8'h00;
        end else if (w_fire) begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_len     <= n_len;
            r_pay_cnt <= n_pay_cnt;
            r_crc     <= n_crc;
            r_crc_lo  <= n_crc_lo;
        end
    end

    // header store, no reset: every frame fills it before it is read
    always_ff @(posedge i_clk) begin
        if (w_fire && w_hdr_wr) begin
            r_hdr[r_hdr_cnt] <= r_in_byte;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_event     <= n_event;
            r_pay_byte  <= n_pay_byte;
            r_pay_index <= n_pay_index;
            r_hdr_ver   <= n_hdr_ver;
            r_hdr_type  <= n_hdr_type;
            r_hdr_node  <= n_hdr_node;
            r_hdr_len   <= n_hdr_len;
            r_crc_rx    <= n_crc_rx;
            r_crc_gen   <= n_crc_gen;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_res     = r_event;
    assign o_payload_byte  = r_pay_byte;
    assign o_payload_index = r_pay_index;
    assign o_hdr_version   = r_hdr_ver;
    assign o_hdr_msg_type  = r_hdr_type;
    assign o_hdr_node_id   = r_hdr_node;
    assign o_hdr_length    = r_hdr_len;
    assign o_crc_received  = r_crc_rx;
    assign o_crc_computed  = r_crc_gen;

`ifndef ASSERT_OFF
    a_event_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_event_res <= sfp_pkg::EV_OVERSIZE))
        else $error("result event code out of range");

    a_crc_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_event_res == sfp_pkg::EV_GOOD
                         || o_event_res == sfp_pkg::EV_BAD_CRC))
        |-> ((o_crc_received == o_crc_computed) == (o_event_res == sfp_pkg::EV_GOOD)))
        else $error("frame verdict disagrees with CRC fields");

    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_res != sfp_pkg::EV_PAYLOAD)
        |-> (o_payload_byte == 8'h00 && o_payload_index == 16'h0000))
        else $error("payload fields set on a non-payload event");

    a_in_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_in_valid)
        else $error("accepted byte lost from input register");
`endif

endmodule
